[hw/rtl/sorted_array_table_unit_defines.svh]
// Assertion macros for the sorted array table.
`ifndef SORTED_ARRAY_TABLE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SAT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted array table check failed");

// Next-cycle implication.
`define SAT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted array table check failed");

`endif

[hw/rtl/sat_pkg.sv]
package sat_pkg;

  localparam int SIZE = 16;
  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CW = $clog2(SIZE + 1);

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [AW-1:0]            addr_t;
  typedef logic [CW-1:0]            cnt_t;
  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [INDEX_W-1:0]       index_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_DELETE = 2'd1;
  localparam func_t FN_READ   = 2'd2;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_INDEX    = 3'd4;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

[hw/rtl/sat_if.sv]
interface sat_in_if;
  logic             valid;
  logic             ready;
  sat_pkg::func_t   func;
  sat_pkg::word_t   value;
  sat_pkg::index_t  index;

  modport source (output valid, output func, output value, output index, input ready);
  modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface sat_out_if;
  logic              valid;
  logic              ready;
  sat_pkg::status_t  status;
  sat_pkg::word_t    data;
  sat_pkg::count_t   count;
  sat_pkg::word_t    smallest;
  sat_pkg::word_t    second_smallest;
  logic              second_small_valid;
  sat_pkg::word_t    largest;
  sat_pkg::word_t    second_largest;
  logic              second_large_valid;

  modport source (output valid, output status, output data, output count,
                  output smallest, output second_smallest, output second_small_valid,
                  output largest, output second_largest, output second_large_valid,
                  input ready);
  modport sink   (input valid, input status, input data, input count,
                  input smallest, input second_smallest, input second_small_valid,
                  input largest, input second_largest, input second_large_valid,
                  output ready);
endinterface

[hw/rtl/sorted_array_table_unit.sv]
// Table of up to SIZE signed 32-bit words kept in ascending order in a
// one-read, one-write RAM. Insert, delete by value and read by index each
// return one result word with status, data, count, smallest/largest and the
// distinct second smallest/largest. The block takes one operation at a time:
// in ready is high only while idle. An insert walks down from the top entry,
// shifting each larger word up one slot; a delete walks up from entry 0,
// shifting words after the match down; a read fetches the indexed entry;
// a refused or unused operation goes straight to the scan.
// Every operation then rescans all stored entries through the same RAM read
// port and a single shared comparator to refresh the summary, then loads
// the output register and returns to idle to take the next word. The
// load waits while the previous result is still held. A finished result sits
// in the output register until taken, and the next operation can be accepted
// meanwhile.
`include "sorted_array_table_unit_defines.svh"

module sorted_array_table_unit (
  input  logic       clk,
  input  logic       rst_n,
  sat_in_if.sink     in_ch,
  sat_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_INS_LAST, S_DEL, S_RD, S_RDW, S_SCAN, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  sat_pkg::word_t   val_r, val_nxt;
  sat_pkg::index_t  idx_r, idx_nxt;
  sat_pkg::cnt_t    cnt_r, cnt_nxt;
  sat_pkg::cnt_t    ptr_r, ptr_nxt;
  logic             dv_r, dv_nxt;
  sat_pkg::addr_t   daddr_r, daddr_nxt;
  logic             found_r, found_nxt;
  sat_pkg::status_t status_r, status_nxt;
  sat_pkg::word_t   data_r, data_nxt;
  sat_pkg::word_t   lo_r, lo_nxt;
  sat_pkg::word_t   lo2_r, lo2_nxt;
  logic             lo2v_r, lo2v_nxt;
  sat_pkg::word_t   hi2_r, hi2_nxt;
  logic             hi2v_r, hi2v_nxt;
  sat_pkg::word_t   prev_r, prev_nxt;

  logic             out_valid_r, out_valid_nxt;
  sat_pkg::status_t out_status_r, out_status_nxt;
  sat_pkg::word_t   out_data_r, out_data_nxt;
  sat_pkg::count_t  out_count_r, out_count_nxt;
  sat_pkg::word_t   out_lo_r, out_lo_nxt;
  sat_pkg::word_t   out_lo2_r, out_lo2_nxt;
  logic             out_lo2v_r, out_lo2v_nxt;
  sat_pkg::word_t   out_hi_r, out_hi_nxt;
  sat_pkg::word_t   out_hi2_r, out_hi2_nxt;
  logic             out_hi2v_r, out_hi2v_nxt;

  logic             ram_we;
  sat_pkg::addr_t   ram_waddr;
  sat_pkg::word_t   ram_wdata;
  sat_pkg::addr_t   ram_raddr;
  sat_pkg::word_t   ram_rdata;

  sat_pkg::word_t   cmp_b;
  sat_pkg::cmp_t    cmp;
  logic             last_entry;
  logic             in_acc;

  sat_ram #(
    .WIDTH (sat_pkg::DATA_W),
    .DEPTH (sat_pkg::SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmp_b = (state_r == S_SCAN) ? prev_r : val_r;

  sat_cmp u_cmp (
    .a   (ram_rdata),
    .b   (cmp_b),
    .res (cmp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign last_entry  = (sat_pkg::CW'(daddr_r) == cnt_r - sat_pkg::CW'(1));

  always_comb begin
    state_nxt      = state_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    dv_nxt         = 1'b0;
    daddr_nxt      = ptr_r[sat_pkg::AW-1:0];
    found_nxt      = found_r;
    status_nxt     = status_r;
    data_nxt       = data_r;
    lo_nxt         = lo_r;
    lo2_nxt        = lo2_r;
    lo2v_nxt       = lo2v_r;
    hi2_nxt        = hi2_r;
    hi2v_nxt       = hi2v_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_lo_nxt     = out_lo_r;
    out_lo2_nxt    = out_lo2_r;
    out_lo2v_nxt   = out_lo2v_r;
    out_hi_nxt     = out_hi_r;
    out_hi2_nxt    = out_hi2_r;
    out_hi2v_nxt   = out_hi2v_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = val_r;
    ram_raddr      = ptr_r[sat_pkg::AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt    = in_ch.value;
          idx_nxt    = in_ch.index;
          status_nxt = sat_pkg::ST_OK;
          data_nxt   = '0;
          found_nxt  = 1'b0;
          ptr_nxt    = '0;
          state_nxt  = S_SCAN;
          case (in_ch.func)
            sat_pkg::FN_INSERT: begin
              if (cnt_r >= sat_pkg::CW'(sat_pkg::SIZE)) begin
                status_nxt = sat_pkg::ST_FULL;
              end else if (cnt_r == '0) begin
                ram_we    = 1'b1;
                ram_wdata = in_ch.value;
                cnt_nxt   = cnt_r + sat_pkg::CW'(1);
              end else begin
                ptr_nxt   = cnt_r - sat_pkg::CW'(1);
                state_nxt = S_INS;
              end
            end
            sat_pkg::FN_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = sat_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_DEL;
              end
            end
            sat_pkg::FN_READ: begin
              if ({{sat_pkg::CW{1'b0}}, in_ch.index} >=
                  {{sat_pkg::INDEX_W{1'b0}}, cnt_r}) begin
                status_nxt = sat_pkg::ST_INDEX;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        ptr_nxt = ptr_r - sat_pkg::CW'(1);
        dv_nxt  = 1'b1;
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = daddr_r + sat_pkg::AW'(1);
          if (cmp.gt) begin
            ram_wdata = ram_rdata;
            if (daddr_r == '0) begin
              dv_nxt    = 1'b0;
              state_nxt = S_INS_LAST;
            end
          end else begin
            cnt_nxt   = cnt_r + sat_pkg::CW'(1);
            ptr_nxt   = '0;
            dv_nxt    = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_INS_LAST: begin
        ram_we    = 1'b1;
        cnt_nxt   = cnt_r + sat_pkg::CW'(1);
        ptr_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_DEL: begin
        if (ptr_r < cnt_r) begin
          ptr_nxt = ptr_r + sat_pkg::CW'(1);
          dv_nxt  = 1'b1;
        end
        if (dv_r) begin
          if (!found_r && cmp.eq) begin
            found_nxt = 1'b1;
            data_nxt  = ram_rdata;
          end else if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = daddr_r - sat_pkg::AW'(1);
            ram_wdata = ram_rdata;
          end
          if (last_entry) begin
            if (found_nxt) begin
              cnt_nxt = cnt_r - sat_pkg::CW'(1);
            end else begin
              status_nxt = sat_pkg::ST_NOTFOUND;
            end
            ptr_nxt   = '0;
            dv_nxt    = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_RD: begin
        ram_raddr = sat_pkg::AW'(idx_r);
        state_nxt = S_RDW;
      end

      S_RDW: begin
        data_nxt  = ram_rdata;
        ptr_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (cnt_r == '0) begin
          lo_nxt    = '0;
          lo2_nxt   = '0;
          lo2v_nxt  = 1'b0;
          hi2_nxt   = '0;
          hi2v_nxt  = 1'b0;
          prev_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          if (ptr_r < cnt_r) begin
            ptr_nxt = ptr_r + sat_pkg::CW'(1);
            dv_nxt  = 1'b1;
          end
          if (dv_r) begin
            if (daddr_r == '0) begin
              lo_nxt   = ram_rdata;
              lo2_nxt  = '0;
              lo2v_nxt = 1'b0;
              hi2_nxt  = '0;
              hi2v_nxt = 1'b0;
            end else if (!cmp.eq) begin
              // sorted: each change of value moves the second-largest up
              hi2_nxt  = prev_r;
              hi2v_nxt = 1'b1;
              if (!lo2v_r) begin
                lo2_nxt  = ram_rdata;
                lo2v_nxt = 1'b1;
              end
            end
            prev_nxt = ram_rdata;
            if (last_entry) begin
              dv_nxt    = 1'b0;
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = data_r;
          out_count_nxt  = sat_pkg::COUNT_W'(cnt_r);
          out_lo_nxt     = lo_r;
          out_lo2_nxt    = lo2_r;
          out_lo2v_nxt   = lo2v_r;
          out_hi_nxt     = prev_r;
          out_hi2_nxt    = hi2_r;
          out_hi2v_nxt   = hi2v_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    daddr_r      <= daddr_nxt;
    status_r     <= status_nxt;
    data_r       <= data_nxt;
    lo_r         <= lo_nxt;
    lo2_r        <= lo2_nxt;
    lo2v_r       <= lo2v_nxt;
    hi2_r        <= hi2_nxt;
    hi2v_r       <= hi2v_nxt;
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_lo_r     <= out_lo_nxt;
    out_lo2_r    <= out_lo2_nxt;
    out_lo2v_r   <= out_lo2v_nxt;
    out_hi_r     <= out_hi_nxt;
    out_hi2_r    <= out_hi2_nxt;
    out_hi2v_r   <= out_hi2v_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.data               = out_data_r;
  assign out_ch.count              = out_count_r;
  assign out_ch.smallest           = out_lo_r;
  assign out_ch.second_smallest    = out_lo2_r;
  assign out_ch.second_small_valid = out_lo2v_r;
  assign out_ch.largest            = out_hi_r;
  assign out_ch.second_largest     = out_hi2_r;
  assign out_ch.second_large_valid = out_hi2v_r;

  // count only moves while an operation is in flight
  `SAT_NEXT(a_cnt_hold, state_r == S_IDLE && !in_acc, $stable(cnt_r))
  // the summary scan and result load never touch the table
  `SAT_IMPLIES(a_no_wr_scan, state_r == S_SCAN || state_r == S_FIN, !ram_we)
  // a new result word only comes from the load state
  `SAT_IMPLIES(a_out_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN)
  // in a sorted table a distinct second smallest exists iff a second largest does
  `SAT_IMPLIES(a_sec_pair, out_valid_r, out_lo2v_r == out_hi2v_r)

endmodule

[hw/rtl/sat_ram.sv]
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sat_cmp.sv]
module sat_cmp (
  input  sat_pkg::word_t a,
  input  sat_pkg::word_t b,
  output sat_pkg::cmp_t  res
);

  always_comb begin
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule

[bench/sorted_array_table_unit_tb.sv]
`timescale 1ns / 1ps

module sorted_array_table_unit_tb;
  import sat_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_OPS  = 1130;
  localparam int SETTLE      = 2 * SIZE + 10;

  localparam word_t W_MIN = word_t'(32'h8000_0000);
  localparam word_t W_MAX = word_t'(32'h7fff_ffff);

  // func code with no operation behind it
  localparam func_t FN_UNUSED = func_t'(3);

  typedef struct {
    status_t status;
    word_t   data;
    count_t  count;
    word_t   smallest;
    word_t   second_smallest;
    logic    second_small_valid;
    word_t   largest;
    word_t   second_largest;
    logic    second_large_valid;
  } table_result_t;

  class sorted_table_tracker;
    word_t         shadow_table[$];
    table_result_t pending_results[$];
    int            mismatches;
    int            checked;
    int            status_seen[5];
    int            peak_fill;

    function void note_op(func_t f, word_t v, index_t ix);
      table_result_t r;
      int pos;
      int n;
      r = '{default: '0};
      r.status = ST_OK;
      case (f)
        FN_INSERT: begin
          if (shadow_table.size() >= SIZE) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < shadow_table.size() && shadow_table[pos] <= v) pos++;
            shadow_table.insert(pos, v);
          end
        end
        FN_DELETE: begin
          if (shadow_table.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pos = 0;
            while (pos < shadow_table.size() && shadow_table[pos] != v) pos++;
            if (pos >= shadow_table.size()) begin
              r.status = ST_NOTFOUND;
            end else begin
              r.data = shadow_table[pos];
              shadow_table.delete(pos);
            end
          end
        end
        FN_READ: begin
          if (int'(ix) >= shadow_table.size()) r.status = ST_INDEX;
          else r.data = shadow_table[ix];
        end
        default: ;
      endcase
      n = shadow_table.size();
      r.count = count_t'(n);
      if (n > 0) begin
        r.smallest = shadow_table[0];
        r.largest  = shadow_table[n-1];
        for (int i = 0; i < n; i++) begin
          if (shadow_table[i] > r.smallest) begin
            r.second_smallest    = shadow_table[i];
            r.second_small_valid = 1'b1;
            break;
          end
        end
        for (int i = n - 1; i >= 0; i--) begin
          if (shadow_table[i] < r.largest) begin
            r.second_largest     = shadow_table[i];
            r.second_large_valid = 1'b1;
            break;
          end
        end
      end
      if (n > peak_fill) peak_fill = n;
      status_seen[r.status]++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("data", want.data, got.data);
      compare_field("count", want.count, got.count);
      compare_field("smallest", want.smallest, got.smallest);
      compare_field("second_smallest", want.second_smallest, got.second_smallest);
      compare_field("second_small_valid", want.second_small_valid, got.second_small_valid);
      compare_field("largest", want.largest, got.largest);
      compare_field("second_largest", want.second_largest, got.second_largest);
      compare_field("second_large_valid", want.second_large_valid, got.second_large_valid);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  sorted_table_tracker tracker;

  sat_in_if  in_ch();
  sat_out_if out_ch();

  sorted_array_table_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sorted_array_table_unit_tb NOT OK");
      $finish;
    end
  end

  // result side: random backpressure in stretches
  initial begin
    int stretch_left;
    int ready_pct;
    out_ch.ready = 1'b0;
    stretch_left = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(1, 60);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 5;
        endcase
      end
      stretch_left--;
      out_ch.ready <= rst_n && ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    table_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status             = out_ch.status;
      got.data               = out_ch.data;
      got.count              = out_ch.count;
      got.smallest           = out_ch.smallest;
      got.second_smallest    = out_ch.second_smallest;
      got.second_small_valid = out_ch.second_small_valid;
      got.largest            = out_ch.largest;
      got.second_largest     = out_ch.second_largest;
      got.second_large_valid = out_ch.second_large_valid;
      tracker.check_result(got);
    end
  end

  task automatic send_op(func_t f, word_t v, index_t ix, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    in_ch.index <= ix;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_op(f, v, ix);
  endtask

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 6))
        0: return W_MIN;
        1: return W_MIN + 1;
        2: return -1;
        3: return 0;
        4: return 1;
        5: return W_MAX - 1;
        default: return W_MAX;
      endcase
    end
    if (r < 65) return word_t'($urandom_range(0, 16)) - 8;
    return word_t'($urandom);
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (mode == 2) return $urandom_range(1, 6);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic run_random(int n_ops);
    int burst_left;
    int insert_pct;
    int gap_mode;
    int r;
    func_t f;
    word_t v;
    index_t ix;
    burst_left = 0;
    insert_pct = 50;
    gap_mode = 0;
    for (int k = 0; k < n_ops; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
        gap_mode = $urandom_range(0, 2);
      end
      burst_left--;
      if (k == n_ops / 2) begin
        // drain everything before carrying on
        in_ch.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
      end
      v  = pick_value();
      ix = index_t'($urandom_range(0, 15));
      r  = $urandom_range(0, 99);
      if (r < 3) begin
        f = FN_UNUSED;
      end else if (r < 13) begin
        f = FN_READ;
      end else if (r < 13 + (87 * insert_pct) / 100) begin
        f = FN_INSERT;
      end else begin
        f = FN_DELETE;
        if (tracker.shadow_table.size() > 0 && $urandom_range(0, 3) != 0)
          v = tracker.shadow_table[$urandom_range(0, tracker.shadow_table.size() - 1)];
      end
      send_op(f, v, ix, pick_gap(gap_mode));
    end
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func  = FN_INSERT;
    in_ch.value = '0;
    in_ch.index = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table corner cases
    send_op(FN_READ,   0, 0, 0);
    send_op(FN_DELETE, 5, 0, 0);
    send_op(FN_UNUSED, 0, 0, 1);
    // extremes and duplicates
    send_op(FN_INSERT, W_MAX, 0, 0);
    send_op(FN_INSERT, W_MIN, 0, 0);
    send_op(FN_INSERT, W_MAX, 0, 2);
    send_op(FN_INSERT, 0, 0, 0);
    send_op(FN_INSERT, -1, 0, 0);
    send_op(FN_INSERT, 0, 0, 0);
    send_op(FN_READ,   0, 0, 0);
    send_op(FN_READ,   0, 5, 0);
    send_op(FN_READ,   0, 6, 3);
    send_op(FN_READ,   0, 15, 0);
    send_op(FN_DELETE, 7, 0, 0);
    send_op(FN_DELETE, W_MAX, 0, 0);
    send_op(FN_DELETE, W_MIN, 0, 0);
    send_op(FN_UNUSED, -1, 15, 0);
    send_op(FN_DELETE, 0, 0, 0);
    send_op(FN_DELETE, 0, 0, 0);
    send_op(FN_DELETE, -1, 0, 0);
    send_op(FN_DELETE, W_MAX, 0, 0);
    send_op(FN_INSERT, 42, 0, 0);
    send_op(FN_DELETE, 42, 0, 0);
    send_op(FN_READ,   0, 15, 0);

    run_random(RANDOM_OPS);
    in_ch.valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d results: ok %0d, full %0d, empty %0d, not found %0d, bad index %0d",
             tracker.checked, tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_NOTFOUND],
             tracker.status_seen[ST_INDEX]);
    $display("peak fill %0d of %0d entries, %0d cycles", tracker.peak_fill, SIZE, cycle_count);
    if (tracker.mismatches == 0) begin
      $display("sorted_array_table_unit_tb OK");
    end else begin
      $display("sorted_array_table_unit_tb NOT OK");
    end
    $finish;
  end

  initial cycle_count = 0;

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_if.sv
hw/rtl/sat_ram.sv
hw/rtl/sat_cmp.sv
hw/rtl/sorted_array_table_unit.sv
bench/sorted_array_table_unit_tb.sv
